/* sv/first_fit_free_list_allocator_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the allocator datapath.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// assertion checked while reset is low
`define FFA_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// assertion checked at every edge, reset included
`define FFA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFA_ASSERT_RST(label, clk, rst, prop, msg)
`define FFA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* sv/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Types and constants of the first-fit free list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int ADDR_W   = 31;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;

   localparam logic [ADDR_W-1:0] ADDR_MAX = 31'h7FFF_FFFF;

   localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FLOOR = 3'd4;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_A_CHK,
      S_A_EV,
      S_F_SCAN,
      S_L_START,
      S_L_EV0,
      S_L_CHK,
      S_L_EV,
      S_L_INS2,
      S_C_START,
      S_C_RD,
      S_C_LATCH,
      S_C_CHK,
      S_C_EV,
      S_FINISH
   } state_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LOAD,
      DP_INIT,
      DP_A_START,
      DP_RD_CUR,
      DP_A_ADV,
      DP_A_EXACT,
      DP_A_CARVE,
      DP_SCAN_CLR,
      DP_SCAN_INC,
      DP_F_WNEW,
      DP_RD_HEAD,
      DP_L_HEADINS,
      DP_L_FIRST,
      DP_L_ADV,
      DP_L_INS1,
      DP_L_INS2,
      DP_C_START,
      DP_C_LATCH,
      DP_RD_CN,
      DP_C_MERGE,
      DP_C_ADV
   } dp_op_type;

   typedef struct packed {
      dp_op_type           op;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            req_zero;
      logic            len_zero;
      logic            below_floor;
      logic            head_valid;
      logic            cur_valid;
      logic            fit;
      logic            exact;
      logic            scan_hit;
      logic            scan_last;
      logic            st_lt_rd;
      logic            cn_valid;
      logic            adjacent;
      logic            out_free;
   } dp_stat_type;

endpackage

/* sv/ffa_req_if.sv */
// ----------------------------------------------------------------------------
// ffa_req_if
// Request channel: operation, start and size with valid/ready.
// ----------------------------------------------------------------------------
interface ffa_req_if;
   logic                        valid;
   logic                        ready;
   logic [ffa_pkg::OP_W-1:0]    opcode;
   logic [ffa_pkg::ADDR_W-1:0]  block_start;
   logic [ffa_pkg::ADDR_W-1:0]  block_size;

   modport source (output valid, output opcode, output block_start, output block_size,
                   input ready);
   modport sink   (input valid, input opcode, input block_start, input block_size,
                   output ready);
endinterface

/* sv/ffa_rsp_if.sv */
// ----------------------------------------------------------------------------
// ffa_rsp_if
// Response channel: status and granted address with valid/ready.
// ----------------------------------------------------------------------------
interface ffa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffa_pkg::STATUS_W-1:0]  status;
   logic [ffa_pkg::ADDR_W-1:0]    alloc_address;

   modport source (output valid, output status, output alloc_address, input ready);
   modport sink   (input valid, input status, input alloc_address, output ready);
endinterface

/* sv/ffa_controller.sv */
// ----------------------------------------------------------------------------
// ffa_controller
// Sequencer for init, allocate walk, free scan, sorted insert and coalesce.
// ----------------------------------------------------------------------------
module ffa_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ffa_pkg::dp_stat_type  stat,
   output ffa_pkg::ctl_cmd_type  cmd
);

   ffa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffa_pkg::S_IDLE: begin
            if (req_valid) state_in = ffa_pkg::S_DISPATCH;
         end
         ffa_pkg::S_DISPATCH: begin
            unique case (stat.opcode)
               ffa_pkg::OP_ALLOC: begin
                  state_in = stat.req_zero ? ffa_pkg::S_FINISH : ffa_pkg::S_A_CHK;
               end
               ffa_pkg::OP_FREE: begin
                  if (stat.len_zero || stat.below_floor) state_in = ffa_pkg::S_FINISH;
                  else state_in = ffa_pkg::S_F_SCAN;
               end
               default: state_in = ffa_pkg::S_FINISH;
            endcase
         end
         ffa_pkg::S_A_CHK: begin
            state_in = stat.cur_valid ? ffa_pkg::S_A_EV : ffa_pkg::S_FINISH;
         end
         ffa_pkg::S_A_EV: begin
            state_in = stat.fit ? ffa_pkg::S_FINISH : ffa_pkg::S_A_CHK;
         end
         ffa_pkg::S_F_SCAN: begin
            if (stat.scan_hit) state_in = ffa_pkg::S_L_START;
            else if (stat.scan_last) state_in = ffa_pkg::S_FINISH;
         end
         ffa_pkg::S_L_START: begin
            state_in = stat.head_valid ? ffa_pkg::S_L_EV0 : ffa_pkg::S_C_START;
         end
         ffa_pkg::S_L_EV0: begin
            state_in = stat.st_lt_rd ? ffa_pkg::S_C_START : ffa_pkg::S_L_CHK;
         end
         ffa_pkg::S_L_CHK: begin
            state_in = stat.cur_valid ? ffa_pkg::S_L_EV : ffa_pkg::S_L_INS2;
         end
         ffa_pkg::S_L_EV: begin
            state_in = stat.st_lt_rd ? ffa_pkg::S_L_INS2 : ffa_pkg::S_L_CHK;
         end
         ffa_pkg::S_L_INS2:  state_in = ffa_pkg::S_C_START;
         ffa_pkg::S_C_START: state_in = ffa_pkg::S_C_RD;
         ffa_pkg::S_C_RD:    state_in = ffa_pkg::S_C_LATCH;
         ffa_pkg::S_C_LATCH: state_in = ffa_pkg::S_C_CHK;
         ffa_pkg::S_C_CHK: begin
            state_in = stat.cn_valid ? ffa_pkg::S_C_EV : ffa_pkg::S_FINISH;
         end
         ffa_pkg::S_C_EV:    state_in = ffa_pkg::S_C_CHK;
         ffa_pkg::S_FINISH: begin
            if (stat.out_free) state_in = ffa_pkg::S_IDLE;
         end
         default: state_in = ffa_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd.op         = ffa_pkg::DP_NOP;
      cmd.set_status = 1'b0;
      cmd.status     = ffa_pkg::ST_OK;
      cmd.out_load   = 1'b0;
      unique case (state_ff)
         ffa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = ffa_pkg::DP_LOAD;
         end
         ffa_pkg::S_DISPATCH: begin
            unique case (stat.opcode)
               ffa_pkg::OP_INIT: begin
                  cmd.op         = ffa_pkg::DP_INIT;
                  cmd.set_status = 1'b1;
               end
               ffa_pkg::OP_ALLOC: begin
                  if (stat.req_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ffa_pkg::ST_ZERO;
                  end else begin
                     cmd.op = ffa_pkg::DP_A_START;
                  end
               end
               ffa_pkg::OP_FREE: begin
                  if (stat.len_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ffa_pkg::ST_ZERO;
                  end else if (stat.below_floor) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ffa_pkg::ST_FLOOR;
                  end else begin
                     cmd.op = ffa_pkg::DP_SCAN_CLR;
                  end
               end
               default: cmd.set_status = 1'b1;
            endcase
         end
         ffa_pkg::S_A_CHK: begin
            if (stat.cur_valid) begin
               cmd.op = ffa_pkg::DP_RD_CUR;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = ffa_pkg::ST_NOFIT;
            end
         end
         ffa_pkg::S_A_EV: begin
            if (stat.fit) begin
               cmd.op         = stat.exact ? ffa_pkg::DP_A_EXACT : ffa_pkg::DP_A_CARVE;
               cmd.set_status = 1'b1;
            end else begin
               cmd.op = ffa_pkg::DP_A_ADV;
            end
         end
         ffa_pkg::S_F_SCAN: begin
            if (stat.scan_hit) begin
               cmd.op = ffa_pkg::DP_F_WNEW;
            end else if (stat.scan_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = ffa_pkg::ST_FULL;
            end else begin
               cmd.op = ffa_pkg::DP_SCAN_INC;
            end
         end
         ffa_pkg::S_L_START: begin
            cmd.op = stat.head_valid ? ffa_pkg::DP_RD_HEAD : ffa_pkg::DP_L_HEADINS;
         end
         ffa_pkg::S_L_EV0: begin
            cmd.op = stat.st_lt_rd ? ffa_pkg::DP_L_HEADINS : ffa_pkg::DP_L_FIRST;
         end
         ffa_pkg::S_L_CHK: begin
            cmd.op = stat.cur_valid ? ffa_pkg::DP_RD_CUR : ffa_pkg::DP_L_INS1;
         end
         ffa_pkg::S_L_EV: begin
            cmd.op = stat.st_lt_rd ? ffa_pkg::DP_L_INS1 : ffa_pkg::DP_L_ADV;
         end
         ffa_pkg::S_L_INS2:  cmd.op = ffa_pkg::DP_L_INS2;
         ffa_pkg::S_C_START: cmd.op = ffa_pkg::DP_C_START;
         ffa_pkg::S_C_RD:    cmd.op = ffa_pkg::DP_RD_CUR;
         ffa_pkg::S_C_LATCH: cmd.op = ffa_pkg::DP_C_LATCH;
         ffa_pkg::S_C_CHK: begin
            if (stat.cn_valid) begin
               cmd.op = ffa_pkg::DP_RD_CN;
            end else begin
               cmd.set_status = 1'b1;
            end
         end
         ffa_pkg::S_C_EV: begin
            cmd.op = stat.adjacent ? ffa_pkg::DP_C_MERGE : ffa_pkg::DP_C_ADV;
         end
         ffa_pkg::S_FINISH: cmd.out_load = stat.out_free;
         default: ;
      endcase
   end

endmodule

/* sv/ffa_datapath.sv */
// ----------------------------------------------------------------------------
// ffa_datapath
// Extent memories, empty flags, list pointers and the response register.
// ----------------------------------------------------------------------------
`include "first_fit_free_list_allocator_core_macros.svh"

module ffa_datapath #(
   parameter int FREE_SLOTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [ffa_pkg::ADDR_W-1:0]    csr_wr_data,
   input  logic [ffa_pkg::OP_W-1:0]      req_opcode,
   input  logic [ffa_pkg::ADDR_W-1:0]    req_block_start,
   input  logic [ffa_pkg::ADDR_W-1:0]    req_block_size,
   input  ffa_pkg::ctl_cmd_type          cmd,
   output ffa_pkg::dp_stat_type          stat,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ffa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ffa_pkg::ADDR_W-1:0]    rsp_alloc_address
);

   localparam int AW = ffa_pkg::ADDR_W;
   localparam int SW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam int LW = $clog2(FREE_SLOTS + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(FREE_SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(FREE_SLOTS - 1);

   logic [AW-1:0] start_mem [FREE_SLOTS];
   logic [AW-1:0] len_mem   [FREE_SLOTS];
   logic [LW-1:0] link_mem  [FREE_SLOTS];

   logic [AW-1:0]               floor_ff;
   logic [FREE_SLOTS-1:0]       empty_ff;
   logic [LW-1:0]               head_ff;
   logic [ffa_pkg::OP_W-1:0]    op_ff;
   logic [AW-1:0]               st_ff, req_ff, len_ff;
   logic [LW-1:0]               cur_ff, prev_ff, cn_ff;
   logic [SW-1:0]               slot_ff;
   logic [AW-1:0]               cs_ff, cl_ff;
   logic [AW-1:0]               rs_ff, rl_ff;
   logic [LW-1:0]               rk_ff;
   logic [ffa_pkg::STATUS_W-1:0] status_ff;
   logic [AW-1:0]               addr_ff;
   logic                        rsp_valid_ff;
   logic [ffa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [AW-1:0]               rsp_addr_ff;

   logic [AW-1:0] room, clamp_len;
   logic [AW:0]   end_sum;
   logic [AW-1:0] merge_len;
   logic          rd_en;
   logic [SW-1:0] rd_addr, wr_addr;
   logic          we_start, we_len, we_link;
   logic [AW-1:0] wd_start, wd_len;
   logic [LW-1:0] wd_link;

   assign room      = ffa_pkg::ADDR_MAX - req_block_start;
   assign clamp_len = (req_block_size > room) ? room : req_block_size;
   assign end_sum   = {1'b0, cs_ff} + {1'b0, cl_ff};
   assign merge_len = cl_ff + rl_ff;

   always_comb begin
      stat.opcode      = op_ff;
      stat.req_zero    = (req_ff == '0);
      stat.len_zero    = (len_ff == '0);
      stat.below_floor = (st_ff < floor_ff);
      stat.head_valid  = (head_ff < NULL_LINK);
      stat.cur_valid   = (cur_ff < NULL_LINK);
      stat.fit         = (rl_ff >= req_ff);
      stat.exact       = (rl_ff == req_ff);
      stat.scan_hit    = empty_ff[slot_ff];
      stat.scan_last   = (slot_ff == LAST_SLOT);
      stat.st_lt_rd    = (st_ff < rs_ff);
      stat.cn_valid    = (cn_ff < NULL_LINK);
      stat.adjacent    = (end_sum == {1'b0, rs_ff});
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // memory port control
   always_comb begin
      rd_en    = 1'b0;
      rd_addr  = cur_ff[SW-1:0];
      wr_addr  = cur_ff[SW-1:0];
      we_start = 1'b0;
      we_len   = 1'b0;
      we_link  = 1'b0;
      wd_start = st_ff;
      wd_len   = len_ff;
      wd_link  = NULL_LINK;
      case (cmd.op)
         ffa_pkg::DP_RD_CUR:  rd_en = 1'b1;
         ffa_pkg::DP_RD_HEAD: begin
            rd_en   = 1'b1;
            rd_addr = head_ff[SW-1:0];
         end
         ffa_pkg::DP_RD_CN: begin
            rd_en   = 1'b1;
            rd_addr = cn_ff[SW-1:0];
         end
         ffa_pkg::DP_INIT: begin
            wr_addr  = '0;
            we_start = (len_ff != '0);
            we_len   = (len_ff != '0);
            we_link  = (len_ff != '0);
         end
         ffa_pkg::DP_A_EXACT: begin
            wr_addr = prev_ff[SW-1:0];
            we_link = (prev_ff < NULL_LINK);
            wd_link = rk_ff;
         end
         ffa_pkg::DP_A_CARVE: begin
            we_start = 1'b1;
            we_len   = 1'b1;
            wd_start = rs_ff + req_ff;
            wd_len   = rl_ff - req_ff;
         end
         ffa_pkg::DP_F_WNEW: begin
            wr_addr  = slot_ff;
            we_start = 1'b1;
            we_len   = 1'b1;
         end
         ffa_pkg::DP_L_HEADINS: begin
            wr_addr = slot_ff;
            we_link = 1'b1;
            wd_link = head_ff;
         end
         ffa_pkg::DP_L_INS1: begin
            wr_addr = prev_ff[SW-1:0];
            we_link = 1'b1;
            wd_link = LW'(slot_ff);
         end
         ffa_pkg::DP_L_INS2: begin
            wr_addr = slot_ff;
            we_link = 1'b1;
            wd_link = cur_ff;
         end
         ffa_pkg::DP_C_MERGE: begin
            we_len  = 1'b1;
            we_link = 1'b1;
            wd_len  = merge_len;
            wd_link = rk_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_start) start_mem[wr_addr] <= wd_start;
      if (we_len)   len_mem[wr_addr]   <= wd_len;
      if (we_link)  link_mem[wr_addr]  <= wd_link;
      if (rd_en) begin
         rs_ff <= start_mem[rd_addr];
         rl_ff <= len_mem[rd_addr];
         rk_ff <= link_mem[rd_addr];
      end
   end

   // control state: floor, empty flags, head, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff     <= '0;
         empty_ff     <= '1;
         head_ff      <= NULL_LINK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) floor_ff <= csr_wr_data;
         case (cmd.op)
            ffa_pkg::DP_INIT: begin
               empty_ff <= {{(FREE_SLOTS-1){1'b1}}, (len_ff == '0)};
               head_ff  <= (len_ff == '0) ? NULL_LINK : '0;
            end
            ffa_pkg::DP_A_EXACT: begin
               empty_ff[cur_ff[SW-1:0]] <= 1'b1;
               if (!(prev_ff < NULL_LINK)) head_ff <= rk_ff;
            end
            ffa_pkg::DP_F_WNEW:    empty_ff[slot_ff] <= 1'b0;
            ffa_pkg::DP_L_HEADINS: head_ff <= LW'(slot_ff);
            ffa_pkg::DP_C_MERGE:   empty_ff[cn_ff[SW-1:0]] <= 1'b1;
            default: ;
         endcase
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // walk pointers and per-transaction payload
   always_ff @(posedge clock) begin
      case (cmd.op) inside
         ffa_pkg::DP_LOAD: begin
            op_ff   <= req_opcode;
            st_ff   <= req_block_start;
            req_ff  <= req_block_size;
            len_ff  <= clamp_len;
            addr_ff <= '0;
         end
         ffa_pkg::DP_A_START: begin
            cur_ff  <= head_ff;
            prev_ff <= NULL_LINK;
         end
         ffa_pkg::DP_A_ADV, ffa_pkg::DP_L_ADV: begin
            prev_ff <= cur_ff;
            cur_ff  <= rk_ff;
         end
         ffa_pkg::DP_A_EXACT, ffa_pkg::DP_A_CARVE: addr_ff <= rs_ff;
         ffa_pkg::DP_SCAN_CLR: slot_ff <= '0;
         ffa_pkg::DP_SCAN_INC: slot_ff <= slot_ff + 1'b1;
         ffa_pkg::DP_L_FIRST: begin
            prev_ff <= head_ff;
            cur_ff  <= rk_ff;
         end
         ffa_pkg::DP_C_START: cur_ff <= head_ff;
         ffa_pkg::DP_C_LATCH: begin
            cs_ff <= rs_ff;
            cl_ff <= rl_ff;
            cn_ff <= rk_ff;
         end
         ffa_pkg::DP_C_MERGE: begin
            cl_ff <= merge_len;
            cn_ff <= rk_ff;
         end
         ffa_pkg::DP_C_ADV: begin
            cur_ff <= cn_ff;
            cs_ff  <= rs_ff;
            cl_ff  <= rl_ff;
            cn_ff  <= rk_ff;
         end
         default: ;
      endcase
      if (cmd.set_status) status_ff <= cmd.status;
      if (cmd.out_load) begin
         rsp_status_ff <= status_ff;
         rsp_addr_ff   <= addr_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_alloc_address = rsp_addr_ff;

   `FFA_ASSERT_RST(a_exact_cur_valid, clock, reset, (cmd.op == ffa_pkg::DP_A_EXACT) |-> (cur_ff < NULL_LINK), "exact fit on a null slot")
   `FFA_ASSERT_RST(a_coalesce_head_valid, clock, reset, (cmd.op == ffa_pkg::DP_C_START) |-> (head_ff < NULL_LINK), "coalesce started on an empty list")
   `FFA_ASSERT_RST(a_new_slot_empty, clock, reset, (cmd.op == ffa_pkg::DP_F_WNEW) |=> !empty_ff[$past(slot_ff)], "new extent slot still marked empty")
   `FFA_ASSERT_RST(a_load_sets_valid, clock, reset, cmd.out_load |=> rsp_valid_ff, "response load lost")

endmodule

/* sv/first_fit_free_list_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// Address-ordered first-fit extent allocator with coalescing on free.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  req_ch    in   valid/ready      opcode, block_start, block_size
//  rsp_ch    out  valid/ready      status, alloc_address
//  csr       in   csr_wr_en        csr_wr_data (data_region_floor)
//
//  One transaction at a time, from accept to response load: init, no-op and
//  zero or below-floor requests go straight to the finish state; allocate
//  reads list nodes in order until one fits; free scans the slots for an
//  empty one, then walks the list for the sorted insert and walks its links
//  for coalescing, all paced by the single read port of the extent memories.
//  Synchronous reset marks every slot empty at once; no clearing pass.
//  The finish cycle stalls while the previous response waits; a new request
//  is taken while the last response still waits.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_core #(
   parameter int FREE_SLOTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [ffa_pkg::ADDR_W-1:0]  csr_wr_data,
   ffa_req_if.sink                     req_ch,
   ffa_rsp_if.source                   rsp_ch
);

   ffa_pkg::ctl_cmd_type cmd;
   ffa_pkg::dp_stat_type stat;

   ffa_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffa_datapath #(
      .FREE_SLOTS (FREE_SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_opcode        (req_ch.opcode),
      .req_block_start   (req_ch.block_start),
      .req_block_size    (req_ch.block_size),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_status        (rsp_ch.status),
      .rsp_alloc_address (rsp_ch.alloc_address)
   );

endmodule
